### rtl/mpsp_pkg.sv
// ----------------------------------------------------------------------------
// mpsp_pkg
// Shared types and codes for the MQTT packet stream parser: token kinds,
// the token record passed between stages and the length-field limit.
// ----------------------------------------------------------------------------
package mpsp_pkg;

  // Maximum number of bytes in the remaining-length varint
  localparam int LEN_FIELD_BYTES = 4;

  typedef enum logic [3:0] {
    K_HDR     = 4'd0,
    K_LEN     = 4'd1,
    K_CFLAGS  = 4'd2,
    K_KA      = 4'd3,
    K_CID     = 4'd4,
    K_WTOPIC  = 4'd5,
    K_WMSG    = 4'd6,
    K_USER    = 4'd7,
    K_PASS    = 4'd8,
    K_TOPIC   = 4'd9,
    K_PKTID   = 4'd10,
    K_PAYLOAD = 4'd11,
    K_QOS     = 4'd12,
    K_STRLEN  = 4'd13,
    K_UNSUP   = 4'd14,
    K_BAD     = 4'd15
  } tok_kind_t;

  // Control packet types that matter to the parser
  localparam logic [3:0] PT_CONNECT     = 4'd1;
  localparam logic [3:0] PT_PUBLISH     = 4'd3;
  localparam logic [3:0] PT_PUBACK      = 4'd4;
  localparam logic [3:0] PT_PUBCOMP     = 4'd7;
  localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  pkt;
    logic [27:0] value;
    logic        pend;
  } tok_t;

endpackage

### rtl/mpsp_in_stage.sv
// ----------------------------------------------------------------------------
// mpsp_in_stage
// Input register: captures one stream byte per beat and holds it until the
// parse stage consumes it.
// ----------------------------------------------------------------------------
module mpsp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       valid,
  output logic [7:0] byte_q
);
  import mpsp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_stall  = valid_r && !take;
  assign valid_nxt = (!valid_r || take) ? in_valid : valid_r;
  assign valid     = valid_r;
  assign byte_q    = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

endmodule

### rtl/mpsp_core.sv
// ----------------------------------------------------------------------------
// mpsp_core
// Parse stage: holds the packet state and turns one byte into at most one
// token in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module mpsp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     in_byte,
  output logic           res_valid,
  output mpsp_pkg::tok_t res
);
  import mpsp_pkg::*;

  typedef enum logic [4:0] {
    PH_HDR     = 5'd0,
    PH_LEN     = 5'd1,
    PH_SKIP    = 5'd2,
    PH_CFLAGS  = 5'd3,
    PH_KA_HI   = 5'd4,
    PH_KA_LO   = 5'd5,
    PH_PID_HI  = 5'd6,
    PH_PID_LO  = 5'd7,
    PH_PAYLOAD = 5'd8,
    PH_QOS     = 5'd9,
    PH_TRAIL   = 5'd10,
    PH_CID_H   = 5'd12,
    PH_CID_L   = 5'd13,
    PH_CID_D   = 5'd14,
    PH_WTP_H   = 5'd15,
    PH_WTP_L   = 5'd16,
    PH_WTP_D   = 5'd17,
    PH_WMS_H   = 5'd18,
    PH_WMS_L   = 5'd19,
    PH_WMS_D   = 5'd20,
    PH_USR_H   = 5'd21,
    PH_USR_L   = 5'd22,
    PH_USR_D   = 5'd23,
    PH_PAS_H   = 5'd24,
    PH_PAS_L   = 5'd25,
    PH_PAS_D   = 5'd26,
    PH_TOP_H   = 5'd27,
    PH_TOP_L   = 5'd28,
    PH_TOP_D   = 5'd29
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [27:0] bytes_left_r, bytes_left_nxt;
  logic [27:0] accum_r, accum_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [15:0] str_left_r, str_left_nxt;
  logic [7:0]  cflags_r, cflags_nxt;
  logic [2:0]  skip_r, skip_nxt;
  logic [7:0]  high_r, high_nxt;

  logic        is_str;
  logic        is_body;
  logic        is_hdr_ph;

  function automatic phase_t after_will(logic [7:0] cf);
    if (cf[7]) return PH_USR_H;
    if (cf[6]) return PH_PAS_H;
    return PH_TRAIL;
  endfunction

  function automatic phase_t after_string(tok_kind_t sk, logic [7:0] cf,
                                          logic [3:0] t, logic [3:0] fl);
    phase_t ph;
    case (sk)
      K_CID:    ph = cf[2] ? PH_WTP_H : after_will(cf);
      K_WTOPIC: ph = PH_WMS_H;
      K_WMSG:   ph = after_will(cf);
      K_USER:   ph = cf[6] ? PH_PAS_H : PH_TRAIL;
      K_PASS:   ph = PH_TRAIL;
      default: begin
        if (t == PT_PUBLISH)          ph = (fl[2:1] != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
        else if (t == PT_SUBSCRIBE)   ph = PH_QOS;
        else if (t == PT_UNSUBSCRIBE) ph = PH_TOP_H;
        else                          ph = PH_TRAIL;
      end
    endcase
    return ph;
  endfunction

  function automatic phase_t after_pid(logic [3:0] t);
    if (t == PT_PUBLISH) return PH_PAYLOAD;
    if (t == PT_SUBSCRIBE || t == PT_UNSUBSCRIBE) return PH_TOP_H;
    return PH_TRAIL;
  endfunction

  function automatic logic end_ok(phase_t nx, logic [3:0] t);
    if (nx == PH_PAYLOAD || nx == PH_TRAIL) return 1'b1;
    return (nx == PH_TOP_H) && (t == PT_SUBSCRIBE || t == PT_UNSUBSCRIBE);
  endfunction

  function automatic logic needs_body(logic [3:0] t);
    return (t == PT_CONNECT) || (t == PT_PUBLISH) ||
           (t >= PT_PUBACK && t <= PT_SUBSCRIBE) || (t == PT_UNSUBSCRIBE);
  endfunction

  assign is_str    = (phase_r >= PH_CID_H) && (phase_r <= PH_TOP_D);
  assign is_body   = ((phase_r >= PH_SKIP) && (phase_r <= PH_TRAIL)) || is_str;
  assign is_hdr_ph = (phase_r != PH_LEN) && !is_body;

  always_comb begin
    logic [27:0] shifted;
    logic [27:0] acc_new;
    logic [2:0]  seen_new;
    logic        last;
    logic        emit;
    tok_kind_t   kind;
    logic [27:0] val;
    phase_t      nx;
    tok_kind_t   sk;
    logic [1:0]  sub;
    logic [15:0] sl_new;
    logic [2:0]  sk_dec;

    phase_nxt      = phase_r;
    type_nxt       = type_r;
    flags_nxt      = flags_r;
    bytes_left_nxt = bytes_left_r;
    accum_nxt      = accum_r;
    seen_nxt       = seen_r;
    str_left_nxt   = str_left_r;
    cflags_nxt     = cflags_r;
    skip_nxt       = skip_r;
    high_nxt       = high_r;
    res_valid      = 1'b0;
    res            = '0;
    last           = 1'b0;
    emit           = 1'b0;
    kind           = K_HDR;
    val            = '0;
    nx             = phase_r;
    sk             = K_CID;
    sub            = 2'd0;
    sl_new         = '0;
    sk_dec         = '0;
    shifted        = '0;
    acc_new        = '0;
    seen_new       = '0;

    // String phases come in triples: length high, length low, data
    case (phase_r)
      PH_CID_H: begin sk = K_CID;    sub = 2'd0; end
      PH_CID_L: begin sk = K_CID;    sub = 2'd1; end
      PH_CID_D: begin sk = K_CID;    sub = 2'd2; end
      PH_WTP_H: begin sk = K_WTOPIC; sub = 2'd0; end
      PH_WTP_L: begin sk = K_WTOPIC; sub = 2'd1; end
      PH_WTP_D: begin sk = K_WTOPIC; sub = 2'd2; end
      PH_WMS_H: begin sk = K_WMSG;   sub = 2'd0; end
      PH_WMS_L: begin sk = K_WMSG;   sub = 2'd1; end
      PH_WMS_D: begin sk = K_WMSG;   sub = 2'd2; end
      PH_USR_H: begin sk = K_USER;   sub = 2'd0; end
      PH_USR_L: begin sk = K_USER;   sub = 2'd1; end
      PH_USR_D: begin sk = K_USER;   sub = 2'd2; end
      PH_PAS_H: begin sk = K_PASS;   sub = 2'd0; end
      PH_PAS_L: begin sk = K_PASS;   sub = 2'd1; end
      PH_PAS_D: begin sk = K_PASS;   sub = 2'd2; end
      PH_TOP_H: begin sk = K_TOPIC;  sub = 2'd0; end
      PH_TOP_L: begin sk = K_TOPIC;  sub = 2'd1; end
      PH_TOP_D: begin sk = K_TOPIC;  sub = 2'd2; end
      default:  begin sk = K_CID;    sub = 2'd0; end
    endcase

    if (fire) begin
      if (phase_r == PH_LEN) begin
        case (seen_r[1:0])
          2'd0:    shifted = {21'd0, in_byte[6:0]};
          2'd1:    shifted = {14'd0, in_byte[6:0], 7'd0};
          2'd2:    shifted = {7'd0, in_byte[6:0], 14'd0};
          default: shifted = {in_byte[6:0], 21'd0};
        endcase
        acc_new   = accum_r | shifted;
        seen_new  = seen_r + 3'd1;
        accum_nxt = acc_new;
        seen_nxt  = seen_new;
        if (in_byte[7]) begin
          // Too many continuation bytes: flag and resync on next byte
          if (seen_new >= 3'(LEN_FIELD_BYTES)) begin
            phase_nxt = PH_HDR;
            res_valid = 1'b1;
            res       = '{kind: K_BAD, pkt: type_r, value: acc_new, pend: 1'b1};
          end
        end else begin
          bytes_left_nxt = acc_new;
          res_valid      = 1'b1;
          if (acc_new == 28'd0) begin
            phase_nxt = PH_HDR;
            res = '{kind: needs_body(type_r) ? K_BAD : K_LEN, pkt: type_r,
                    value: 28'd0, pend: 1'b1};
          end else begin
            if (type_r == PT_CONNECT) begin
              phase_nxt = PH_SKIP;
              skip_nxt  = 3'd7;
            end else if (type_r == PT_PUBLISH) begin
              phase_nxt = PH_TOP_H;
            end else if (needs_body(type_r)) begin
              phase_nxt = PH_PID_HI;
            end else begin
              phase_nxt = PH_TRAIL;
            end
            res = '{kind: K_LEN, pkt: type_r, value: acc_new, pend: 1'b0};
          end
        end
      end else if (is_hdr_ph) begin
        type_nxt  = in_byte[7:4];
        flags_nxt = in_byte[3:0];
        accum_nxt = '0;
        seen_nxt  = '0;
        phase_nxt = PH_LEN;
        res_valid = 1'b1;
        res = '{kind: K_HDR, pkt: in_byte[7:4], value: 28'(in_byte), pend: 1'b0};
      end else begin
        last           = (bytes_left_r <= 28'd1);
        bytes_left_nxt = (bytes_left_r != 28'd0) ? bytes_left_r - 28'd1 : 28'd0;
        if (is_str) begin
          if (sub == 2'd0) begin
            high_nxt = in_byte;
            nx       = phase_t'(phase_r + 5'd1);
          end else if (sub == 2'd1) begin
            sl_new       = {high_r, in_byte};
            str_left_nxt = sl_new;
            emit = 1'b1;
            kind = K_STRLEN;
            val  = 28'(sl_new);
            nx   = (sl_new != 16'd0) ? phase_t'(phase_r + 5'd1)
                                     : after_string(sk, cflags_r, type_r, flags_r);
          end else begin
            sl_new       = (str_left_r != 16'd0) ? str_left_r - 16'd1 : 16'd0;
            str_left_nxt = sl_new;
            emit = 1'b1;
            kind = sk;
            val  = 28'(in_byte);
            nx   = (sl_new != 16'd0) ? phase_r
                                     : after_string(sk, cflags_r, type_r, flags_r);
          end
        end else begin
          case (phase_r)
            PH_SKIP: begin
              sk_dec   = (skip_r != 3'd0) ? skip_r - 3'd1 : 3'd0;
              skip_nxt = sk_dec;
              if (sk_dec == 3'd0) nx = PH_CFLAGS;
            end
            PH_CFLAGS: begin
              cflags_nxt = in_byte;
              emit = 1'b1;
              kind = K_CFLAGS;
              val  = 28'(in_byte);
              nx   = PH_KA_HI;
            end
            PH_KA_HI: begin
              high_nxt = in_byte;
              nx       = PH_KA_LO;
            end
            PH_KA_LO: begin
              emit = 1'b1;
              kind = K_KA;
              val  = 28'({high_r, in_byte});
              nx   = PH_CID_H;
            end
            PH_PID_HI: begin
              high_nxt = in_byte;
              nx       = PH_PID_LO;
            end
            PH_PID_LO: begin
              emit = 1'b1;
              kind = K_PKTID;
              val  = 28'({high_r, in_byte});
              nx   = after_pid(type_r);
            end
            PH_PAYLOAD: begin
              emit = 1'b1;
              kind = K_PAYLOAD;
              val  = 28'(in_byte);
            end
            PH_QOS: begin
              emit = 1'b1;
              kind = K_QOS;
              val  = 28'(in_byte);
              nx   = PH_TOP_H;
            end
            default: begin
              emit = 1'b1;
              kind = K_UNSUP;
              val  = 28'(in_byte);
              nx   = PH_TRAIL;
            end
          endcase
        end

        if (last) begin
          // Final byte of the packet: replace the token if a field is cut short
          phase_nxt = PH_HDR;
          res_valid = 1'b1;
          if (emit && end_ok(nx, type_r)) begin
            res = '{kind: kind, pkt: type_r, value: val, pend: 1'b1};
          end else begin
            res = '{kind: K_BAD, pkt: type_r, value: 28'(in_byte), pend: 1'b1};
          end
        end else begin
          phase_nxt = nx;
          res_valid = emit;
          res       = '{kind: kind, pkt: type_r, value: val, pend: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR;
      type_r       <= '0;
      flags_r      <= '0;
      bytes_left_r <= '0;
      accum_r      <= '0;
      seen_r       <= '0;
      str_left_r   <= '0;
      cflags_r     <= '0;
      skip_r       <= '0;
      high_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      type_r       <= type_nxt;
      flags_r      <= flags_nxt;
      bytes_left_r <= bytes_left_nxt;
      accum_r      <= accum_nxt;
      seen_r       <= seen_nxt;
      str_left_r   <= str_left_nxt;
      cflags_r     <= cflags_nxt;
      skip_r       <= skip_nxt;
      high_r       <= high_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_end_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.pend |=> phase_r == PH_HDR)
    else $error("packet end did not return to header phase");

  a_hdr_to_len: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_hdr_ph |=> phase_r == PH_LEN && seen_r == 3'd0 && accum_r == 28'd0)
    else $error("header byte did not start a clean length decode");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(bytes_left_r))
    else $error("parse state moved without a beat");

  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != 3'd0)
    else $error("protocol name skip entered with empty count");
`endif

endmodule

### rtl/mpsp_out_stage.sv
// ----------------------------------------------------------------------------
// mpsp_out_stage
// Result register: holds one token until the downstream side takes it and
// tells the parse stage when a new byte may be consumed.
// ----------------------------------------------------------------------------
module mpsp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  mpsp_pkg::tok_t res,
  output logic           ready,
  output logic           out_valid,
  input  logic           out_stall,
  output mpsp_pkg::tok_t tok
);
  import mpsp_pkg::*;

  logic valid_r;
  logic valid_nxt;
  tok_t tok_r;

  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = ready ? res_valid : valid_r;
  assign out_valid = valid_r;
  assign tok       = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (ready && res_valid) begin
      tok_r <= res;
    end
  end

endmodule

### rtl/mqtt_packet_stream_parser_top.sv
// ----------------------------------------------------------------------------
// mqtt_packet_stream_parser_top
// MQTT control packet tokenizer: one stream byte in, at most one token out.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and sustains that rate indefinitely
// while the output side keeps up; a byte is held in the input register,
// and the parse stage then loads its token into the result register. The
// single parse stage that holds the packet state sets this rate: each byte
// reads and updates that state once. A stalled output holds the parse
// stage, and the input stalls while its register holds a byte that the
// parse stage cannot take. Length continuation, skipped protocol-name and
// 16-bit high bytes produce no token; every other byte, the header byte
// included, produces one.
// A length field longer than four bytes, or a packet that ends inside a
// field, gives a malformed token with packet_end set, and parsing resumes
// at the next byte as a fresh header.
module mqtt_packet_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [3:0]  out_packet_kind,
  output logic [27:0] out_token_value,
  output logic        out_packet_end
);
  import mpsp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_ready;
  logic       fire;
  logic       res_valid;
  tok_t       res;
  tok_t       tok;

  assign fire = s1_valid && out_ready;

  mpsp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .take     (out_ready),
    .valid    (s1_valid),
    .byte_q   (s1_byte)
  );

  mpsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .in_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mpsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tok       (tok)
  );

  assign out_token_kind  = tok.kind;
  assign out_packet_kind = tok.pkt;
  assign out_token_value = tok.value;
  assign out_packet_end  = tok.pend;

endmodule
